// ----- sv/twap_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TWAP slice scheduler package
// Shared widths, register indexes, sequencer states and divider bundles.
// ----------------------------------------------------------------------------
package twap_pkg;

	localparam int QTY_W   = 16;
	localparam int TIME_W  = 32;
	localparam int MT_W    = 17;
	localparam int MS_W    = 16;
	localparam int IV_W    = 17;
	localparam int PROD_W  = 33;
	localparam int DIVD_W  = 33;
	localparam int DIVS_W  = 17;
	localparam int CNT_W   = 17;
	localparam int DCNT_W  = 6;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [MT_W-1:0] MAX_TIME_RST = MT_W'(3600);
	localparam logic [MS_W-1:0] MIN_SIZE_RST = MS_W'(1);
	localparam logic [IV_W-1:0] INTERVAL_RST = IV_W'(30);

	localparam logic [1:0] REG_MAX_TIME = 2'd0;
	localparam logic [1:0] REG_MIN_SIZE = 2'd1;
	localparam logic [1:0] REG_INTERVAL = 2'd2;

	typedef struct packed {
		logic [MT_W-1:0] max_time;
		logic [MS_W-1:0] min_size;
		logic [IV_W-1:0] interval;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quot;
		logic [DIVS_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_NUM,
		ST_MUL_MIN,
		ST_DECIDE,
		ST_DIV1,
		ST_DIV2,
		ST_EMIT,
		ST_MARK
	} state_t;

endpackage

// ----- sv/twap_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TWAP request channel
// Carries one request item: total quantity and start time.
// ----------------------------------------------------------------------------
interface twap_req_if import twap_pkg::*;;
	logic              valid;
	logic              ready;
	logic [QTY_W-1:0]  total_qty;
	logic [TIME_W-1:0] start_time;

	modport source (output valid, output total_qty, output start_time, input ready);
	modport sink (input valid, input total_qty, input start_time, output ready);
endinterface

// ----- sv/twap_slice_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TWAP slice channel
// Carries one scheduled slice item with its flags.
// ----------------------------------------------------------------------------
interface twap_slice_if import twap_pkg::*;;
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] slice_time;
	logic [QTY_W-1:0]  slice_qty;
	logic              last_slice;
	logic              empty_plan;
	logic              truncated;

	modport source (output valid, output slice_time, output slice_qty, output last_slice,
		output empty_plan, output truncated, input ready);
	modport sink (input valid, input slice_time, input slice_qty, input last_slice,
		input empty_plan, input truncated, output ready);
endinterface

// ----- sv/twap_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TWAP configuration registers
// APB-style register file for horizon, minimum slice size and interval.
// ----------------------------------------------------------------------------
module twap_cfg import twap_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [MT_W-1:0] max_time_q;
	logic [MS_W-1:0] min_size_q;
	logic [IV_W-1:0] interval_q;
	logic [1:0]      idx;
	logic            wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_time_q <= MAX_TIME_RST;
			min_size_q <= MIN_SIZE_RST;
			interval_q <= INTERVAL_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_MAX_TIME: max_time_q <= pwdata[MT_W-1:0];
				REG_MIN_SIZE: min_size_q <= pwdata[MS_W-1:0];
				REG_INTERVAL: interval_q <= pwdata[IV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MAX_TIME: prdata = DATA_W'(max_time_q);
			REG_MIN_SIZE: prdata = DATA_W'(min_size_q);
			REG_INTERVAL: prdata = DATA_W'(interval_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.max_time = max_time_q;
	assign cfg.min_size = min_size_q;
	assign cfg.interval = interval_q;

endmodule

// ----- sv/twap_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TWAP shared divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twap_div import twap_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dsr_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVS_W:0]   rem_sh;
	logic              ge;

	// The partial remainder stays below the divisor, so one extra bit holds the shift.
	assign rem_sh = {rem_q, quo_q[DIVD_W-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DCNT_W'(DIVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DCNT_W'(1);
			if (cnt_q == DCNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], ge};
			rem_q <= ge ? DIVS_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[DIVS_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ----- sv/twap_slice_scheduler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TWAP slice scheduler
// Turns one request into a time-weighted schedule of slice items.
// ----------------------------------------------------------------------------
//  channel  direction  handshake       payload
//  req      in         valid/ready     total_qty, start_time
//  sched    out        valid/ready     slice_time, slice_qty, last_slice,
//                                      empty_plan, truncated
//  apb      in         psel/penable    max_time, min_size, interval
//
// After acceptance a zero quantity passes through ST_MUL_NUM, ST_MUL_MIN, the
// decision state and the marker. Any other request runs the shared divider
// once in minimum-size mode or twice in normal mode, each pass shifting out 33
// quotient bits, then emits one slice per cycle while the output is not
// stalled, or the marker if the slice count is zero. req.ready is high only
// while the sequencer is idle. A stalled output holds its slice and the
// sequencer waits. Reset is asynchronous and restores the register defaults.
// ----------------------------------------------------------------------------
module twap_slice_scheduler_unit import twap_pkg::*; #(
	parameter int MAX_SLICES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	twap_req_if.sink           req,
	twap_slice_if.source       sched,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	localparam int KW = $clog2(MAX_SLICES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLICES);

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;
	state_t   state_q, state_nx;

	logic [MT_W-1:0]   mt_eff;
	logic [MS_W-1:0]   ms_eff;
	logic [IV_W-1:0]   iv_eff;

	logic [QTY_W-1:0]  total_q;
	logic [TIME_W-1:0] t_q;
	logic [PROD_W-1:0] num_q;
	logic [PROD_W-1:0] lim_q;
	logic              mode_min_q;
	logic [DIVD_W-1:0] share_q;
	logic [MT_W-1:0]   frac_q;
	logic [QTY_W-1:0]  full_q;
	logic [QTY_W-1:0]  rmin_q;
	logic [CNT_W-1:0]  count_q;
	logic [MT_W-1:0]   acc_q;
	logic [KW-1:0]     k_q;

	logic              out_valid_q;
	logic [TIME_W-1:0] out_time_q;
	logic [QTY_W-1:0]  out_qty_q;
	logic              out_last_q;
	logic              out_empty_q;
	logic              out_trunc_q;

	logic [MT_W-1:0]   mul_a;
	logic [MS_W-1:0]   mul_b;
	logic [PROD_W-1:0] prod;
	logic              slot_free;
	logic              accept;
	logic              load_slice;
	logic              load_mark;

	logic [MT_W:0]     acc_sum;
	logic              carry;
	logic [MT_W-1:0]   acc_nx;
	logic              round_up;
	logic [DIVD_W:0]   qty_sum;
	logic [QTY_W-1:0]  qty_norm;
	logic [QTY_W-1:0]  qty_slice;
	logic [CNT_W-1:0]  k_next;
	logic [CNT_W-1:0]  emitn;
	logic              trunc;
	logic              last;

	twap_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	twap_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// A register value of zero counts as one.
	assign mt_eff = (cfg.max_time == '0) ? MT_W'(1) : cfg.max_time;
	assign ms_eff = (cfg.min_size == '0) ? MS_W'(1) : cfg.min_size;
	assign iv_eff = (cfg.interval == '0) ? IV_W'(1) : cfg.interval;

	assign slot_free = !out_valid_q || sched.ready;
	assign accept    = req.valid && req.ready;

	// Shared multiplier: share numerator first, then the minimum-size bound.
	assign mul_a = (state_q == ST_MUL_NUM) ? iv_eff : mt_eff;
	assign mul_b = (state_q == ST_MUL_NUM) ? total_q : ms_eff;
	assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Bresenham carry of the fractional share, plus rounding on the final slice.
	assign acc_sum  = {1'b0, acc_q} + {1'b0, frac_q};
	assign carry    = acc_sum >= {1'b0, mt_eff};
	assign acc_nx   = carry ? MT_W'(acc_sum - {1'b0, mt_eff}) : acc_sum[MT_W-1:0];
	assign k_next   = CNT_W'(k_q) + CNT_W'(1);
	assign round_up = (k_next == count_q) && (acc_nx != '0) &&
		({acc_nx, 1'b0} >= {1'b0, mt_eff});
	assign qty_sum  = {1'b0, share_q} + (DIVD_W + 1)'(carry) + (DIVD_W + 1)'(round_up);
	assign qty_norm = (|qty_sum[DIVD_W:QTY_W]) ? {QTY_W{1'b1}} : qty_sum[QTY_W-1:0];
	assign qty_slice = mode_min_q ?
		((CNT_W'(k_q) < CNT_W'(full_q)) ? ms_eff : rmin_q) : qty_norm;

	assign trunc = count_q > MAX_CNT;
	assign emitn = trunc ? MAX_CNT : count_q;
	assign last  = k_next == emitn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:    if (req.valid) state_nx = ST_MUL_NUM;
			ST_MUL_NUM: state_nx = ST_MUL_MIN;
			ST_MUL_MIN: state_nx = ST_DECIDE;
			ST_DECIDE:  state_nx = (total_q == '0) ? ST_MARK : ST_DIV1;
			ST_DIV1: begin
				if (div_rsp.done) state_nx = mode_min_q ? ST_EMIT : ST_DIV2;
			end
			ST_DIV2: begin
				if (div_rsp.done) state_nx = (div_rsp.quot == '0) ? ST_MARK : ST_EMIT;
			end
			ST_EMIT:    if (slot_free && last) state_nx = ST_IDLE;
			ST_MARK:    if (slot_free) state_nx = ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready        = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = DIVD_W'(total_q);
		div_req.divisor  = DIVS_W'(ms_eff);
		load_slice       = 1'b0;
		load_mark        = 1'b0;
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_DECIDE: begin
				if (total_q != '0) begin
					div_req.start = 1'b1;
					if (!(num_q < lim_q)) begin
						div_req.dividend = num_q;
						div_req.divisor  = DIVS_W'(mt_eff);
					end
				end
			end
			ST_DIV1: begin
				if (div_rsp.done && !mode_min_q) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIVD_W'(mt_eff);
					div_req.divisor  = DIVS_W'(iv_eff);
				end
			end
			ST_EMIT: load_slice = slot_free;
			ST_MARK: load_mark  = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			total_q <= req.total_qty;
			t_q     <= req.start_time;
			k_q     <= '0;
			acc_q   <= '0;
		end
		if (state_q == ST_MUL_NUM) num_q <= prod;
		if (state_q == ST_MUL_MIN) lim_q <= prod;
		if (state_q == ST_DECIDE) mode_min_q <= num_q < lim_q;
		if (state_q == ST_DIV1 && div_rsp.done) begin
			if (mode_min_q) begin
				full_q  <= div_rsp.quot[QTY_W-1:0];
				rmin_q  <= div_rsp.rem[QTY_W-1:0];
				count_q <= CNT_W'(div_rsp.quot[QTY_W-1:0]) +
					CNT_W'(div_rsp.rem != '0);
			end else begin
				share_q <= div_rsp.quot;
				frac_q  <= div_rsp.rem;
			end
		end
		if (state_q == ST_DIV2 && div_rsp.done) begin
			count_q <= div_rsp.quot[CNT_W-1:0];
		end
		if (load_slice) begin
			k_q   <= KW'(k_next);
			t_q   <= t_q + TIME_W'(iv_eff);
			acc_q <= acc_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_slice || load_mark) begin
			out_valid_q <= 1'b1;
		end else if (sched.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_slice) begin
			out_time_q  <= t_q;
			out_qty_q   <= qty_slice;
			out_last_q  <= last;
			out_empty_q <= 1'b0;
			out_trunc_q <= trunc;
		end else if (load_mark) begin
			out_time_q  <= t_q;
			out_qty_q   <= '0;
			out_last_q  <= 1'b1;
			out_empty_q <= 1'b1;
			out_trunc_q <= 1'b0;
		end
	end

	assign sched.valid      = out_valid_q;
	assign sched.slice_time = out_time_q;
	assign sched.slice_qty  = out_qty_q;
	assign sched.last_slice = out_last_q;
	assign sched.empty_plan = out_empty_q;
	assign sched.truncated  = out_trunc_q;

endmodule
